>>> design/hid_keyboard_report_to_scancodes_defines.svh
// Assertion macros shared by the scancode converter modules.
// No dependencies; included by the controller and the datapath.
`ifndef HID_KEYBOARD_REPORT_TO_SCANCODES_DEFINES_SVH
`define HID_KEYBOARD_REPORT_TO_SCANCODES_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HKBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HKBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/hkbs_pkg.sv
// Types, command and status structs and lookup tables for the HID to PS/2 converter.
// No dependencies; used by hkbs_ctrl, hkbs_datapath and the top level.
`timescale 1ns / 1ps

package hkbs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_REL,
    ST_MAK,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_MOD,
    PH_REL,
    PH_MAK
  } phase_t;

  typedef struct packed {
    logic   load;
    logic   step;
    phase_t phase;
    logic   flush;
  } cmd_t;

  typedef struct packed {
    logic step_ok;
    logic flush_ok;
    logic idx_end;
  } status_t;

  localparam logic [7:0] REL_BIT = 8'h80;

  localparam logic [7:0] MOD_MAP [8] = '{
    8'h1D, 8'h2A, 8'h38, 8'h00,
    8'h1D, 8'h36, 8'h38, 8'h00
  };

  function automatic logic [7:0] usage_map(input logic [7:0] code);
    logic [7:0] sc;
    case (code)
      8'h04: sc = 8'h1E;  8'h05: sc = 8'h30;  8'h06: sc = 8'h2E;  8'h07: sc = 8'h20;
      8'h08: sc = 8'h12;  8'h09: sc = 8'h21;  8'h0A: sc = 8'h22;  8'h0B: sc = 8'h23;
      8'h0C: sc = 8'h17;  8'h0D: sc = 8'h24;  8'h0E: sc = 8'h25;  8'h0F: sc = 8'h26;
      8'h10: sc = 8'h32;  8'h11: sc = 8'h31;  8'h12: sc = 8'h18;  8'h13: sc = 8'h19;
      8'h14: sc = 8'h10;  8'h15: sc = 8'h13;  8'h16: sc = 8'h1F;  8'h17: sc = 8'h14;
      8'h18: sc = 8'h16;  8'h19: sc = 8'h2F;  8'h1A: sc = 8'h11;  8'h1B: sc = 8'h2D;
      8'h1C: sc = 8'h15;  8'h1D: sc = 8'h2C;  8'h1E: sc = 8'h02;  8'h1F: sc = 8'h03;
      8'h20: sc = 8'h04;  8'h21: sc = 8'h05;  8'h22: sc = 8'h06;  8'h23: sc = 8'h07;
      8'h24: sc = 8'h08;  8'h25: sc = 8'h09;  8'h26: sc = 8'h0A;  8'h27: sc = 8'h0B;
      8'h28: sc = 8'h1C;  8'h29: sc = 8'h01;  8'h2A: sc = 8'h0E;  8'h2B: sc = 8'h0F;
      8'h2C: sc = 8'h39;  8'h2D: sc = 8'h0C;  8'h2E: sc = 8'h0D;  8'h2F: sc = 8'h1A;
      8'h30: sc = 8'h1B;  8'h31: sc = 8'h2B;  8'h33: sc = 8'h27;  8'h34: sc = 8'h28;
      8'h35: sc = 8'h29;  8'h36: sc = 8'h33;  8'h37: sc = 8'h34;  8'h38: sc = 8'h35;
      8'h39: sc = 8'h3A;  8'h3A: sc = 8'h3B;  8'h3B: sc = 8'h3C;  8'h3C: sc = 8'h3D;
      8'h3D: sc = 8'h3E;  8'h3E: sc = 8'h3F;  8'h3F: sc = 8'h40;  8'h40: sc = 8'h41;
      8'h41: sc = 8'h42;  8'h42: sc = 8'h43;  8'h43: sc = 8'h44;  8'h4F: sc = 8'h4D;
      8'h50: sc = 8'h4B;  8'h51: sc = 8'h50;  8'h52: sc = 8'h48;
      default: sc = 8'h00;
    endcase
    return sc;
  endfunction

endpackage

>>> design/hkbs_ctrl.sv
// Controller state machine: walks modifier, release and make phases per report.
// Depends on hkbs_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "hid_keyboard_report_to_scancodes_defines.svh"

module hkbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ok,
  output logic               in_ready,
  input  hkbs_pkg::status_t  status,
  output hkbs_pkg::cmd_t     cmd
);

  hkbs_pkg::state_t state;
  hkbs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hkbs_pkg::ST_IDLE: begin
        if (in_valid && in_ok) state_next = hkbs_pkg::ST_MOD;
      end
      hkbs_pkg::ST_MOD: begin
        if (status.step_ok && status.idx_end) state_next = hkbs_pkg::ST_REL;
      end
      hkbs_pkg::ST_REL: begin
        if (status.step_ok && status.idx_end) state_next = hkbs_pkg::ST_MAK;
      end
      hkbs_pkg::ST_MAK: begin
        if (status.step_ok && status.idx_end) state_next = hkbs_pkg::ST_FLUSH;
      end
      hkbs_pkg::ST_FLUSH: begin
        if (status.flush_ok) state_next = hkbs_pkg::ST_IDLE;
      end
      default: state_next = hkbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    cmd.phase = hkbs_pkg::PH_MOD;
    cmd.flush = 1'b0;
    case (state)
      hkbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      hkbs_pkg::ST_MOD: begin
        cmd.step = 1'b1;
      end
      hkbs_pkg::ST_REL: begin
        cmd.step  = 1'b1;
        cmd.phase = hkbs_pkg::PH_REL;
      end
      hkbs_pkg::ST_MAK: begin
        cmd.step  = 1'b1;
        cmd.phase = hkbs_pkg::PH_MAK;
      end
      hkbs_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `HKBS_ASSERT_NEXT(a_ok_starts_scan, clk, rst, in_ready && in_valid && in_ok,
                    state == hkbs_pkg::ST_MOD && !in_ready, "accepted report did not start scan")
  `HKBS_ASSERT_NOW(a_no_step_when_ready, clk, rst, in_ready,
                   !cmd.step && !cmd.flush, "scan command while accepting")

endmodule

>>> design/hkbs_datapath.sv
// Datapath: report registers, previous report, slot scan, pending and output registers.
// Depends on hkbs_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "hid_keyboard_report_to_scancodes_defines.svh"

module hkbs_datapath #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hkbs_pkg::cmd_t             cmd,
  output hkbs_pkg::status_t          status,
  input  logic [8+8*KEY_SLOTS-1:0]   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_code,
  output logic                       out_last
);

  localparam int IDX_N  = (KEY_SLOTS > 8) ? KEY_SLOTS : 8;
  localparam int IDX_W  = $clog2(IDX_N);
  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic [7:0]       cur_mods;
  logic [7:0]       cur_keys [KEY_SLOTS];
  logic [7:0]       prev_mods;
  logic [7:0]       prev_keys [KEY_SLOTS];
  logic [IDX_W-1:0] idx;
  logic             pend_valid;
  logic [7:0]       pend_code;

  logic [SLOT_W-1:0] sidx;
  logic [2:0]        midx;
  logic [7:0]        changed;
  logic [7:0]        rel_key;
  logic [7:0]        mak_key;
  logic              rel_hit;
  logic              mak_hit;
  logic [7:0]        rel_sc;
  logic [7:0]        mak_sc;
  logic              cand_valid;
  logic [7:0]        cand_code;
  logic              out_free;
  logic              out_load;

  assign sidx    = idx[SLOT_W-1:0];
  assign midx    = idx[2:0];
  assign changed = cur_mods ^ prev_mods;
  assign rel_key = prev_keys[sidx];
  assign mak_key = cur_keys[sidx];
  assign rel_sc  = hkbs_pkg::usage_map(rel_key);
  assign mak_sc  = hkbs_pkg::usage_map(mak_key);

  always_comb begin
    rel_hit = 1'b0;
    mak_hit = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (cur_keys[j] == rel_key) rel_hit = 1'b1;
      if (prev_keys[j] == mak_key) mak_hit = 1'b1;
    end
  end

  always_comb begin
    cand_valid = 1'b0;
    cand_code  = 8'h00;
    case (cmd.phase)
      hkbs_pkg::PH_MOD: begin
        cand_valid = changed[midx] && (hkbs_pkg::MOD_MAP[midx] != 8'h00);
        cand_code  = cur_mods[midx] ? hkbs_pkg::MOD_MAP[midx]
                                    : (hkbs_pkg::MOD_MAP[midx] | hkbs_pkg::REL_BIT);
      end
      hkbs_pkg::PH_REL: begin
        cand_valid = (rel_key != 8'h00) && !rel_hit && (rel_sc != 8'h00);
        cand_code  = rel_sc | hkbs_pkg::REL_BIT;
      end
      hkbs_pkg::PH_MAK: begin
        cand_valid = (mak_key != 8'h00) && !mak_hit && (mak_sc != 8'h00);
        cand_code  = mak_sc;
      end
      default: begin
        cand_valid = 1'b0;
      end
    endcase
  end

  assign out_free        = !out_valid || out_ready;
  assign status.step_ok  = !(cand_valid && pend_valid && !out_free);
  assign status.flush_ok = !pend_valid || out_free;
  assign status.idx_end  = (cmd.phase == hkbs_pkg::PH_MOD) ? (idx == IDX_W'(7))
                                                           : (idx == IDX_W'(KEY_SLOTS - 1));
  assign out_load = (cmd.step && status.step_ok && cand_valid && pend_valid) ||
                    (cmd.flush && status.flush_ok && pend_valid);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_mods <= in_data[7:0];
      for (int j = 0; j < KEY_SLOTS; j++) begin
        cur_keys[j] <= in_data[8+8*j +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      prev_mods  <= 8'h00;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        prev_keys[j] <= 8'h00;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.step && status.step_ok) begin
        idx <= status.idx_end ? '0 : idx + IDX_W'(1);
        if (cand_valid) begin
          pend_valid <= 1'b1;
          pend_code  <= cand_code;
          if (pend_valid) begin
            out_code  <= pend_code;
            out_last  <= 1'b0;
          end
        end
      end
      if (cmd.flush && status.flush_ok) begin
        prev_mods <= cur_mods;
        for (int j = 0; j < KEY_SLOTS; j++) begin
          prev_keys[j] <= cur_keys[j];
        end
        if (pend_valid) begin
          pend_valid <= 1'b0;
          out_code   <= pend_code;
          out_last   <= 1'b1;
        end
      end
    end
  end

  `HKBS_ASSERT_NEXT(a_pend_held, clk, rst, cmd.step && cand_valid && pend_valid && !out_free,
                    pend_valid && $stable(pend_code), "pending scancode lost on stall")
  `HKBS_ASSERT_NEXT(a_flush_last, clk, rst, cmd.flush && pend_valid && out_free,
                    out_valid && out_last && !pend_valid, "flush did not mark final scancode")
  `HKBS_ASSERT_NOW(a_slot_range, clk, rst, cmd.step && (cmd.phase != hkbs_pkg::PH_MOD),
                   int'(idx) < KEY_SLOTS, "slot index out of range")

endmodule

>>> design/hid_keyboard_report_to_scancodes.sv
// A report is accepted, then walks eight modifier steps, a release scan and a make scan
// of the key slots, and one flush before returning to idle; output stall holds it longer.
// New reports are accepted only in idle; the scan takes one candidate per cycle unless the output stalls.
// Scancodes leave through a single output register; the last is tagged on tlast.
// Reset (rst, synchronous, active high) clears previous modifiers and keys to zero.
// Depends on hkbs_pkg, hkbs_ctrl and hkbs_datapath.
`timescale 1ns / 1ps

module hid_keyboard_report_to_scancodes #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [8+8*KEY_SLOTS-1:0] s_tdata,  // modifier_bits, key_slot0 .. key_slotN
  input  logic                     s_tuser,  // transfer_ok
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,  // scancode
  output logic                     m_tlast   // last_of_run
);

  hkbs_pkg::cmd_t    cmd;
  hkbs_pkg::status_t status;

  hkbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ok    (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hkbs_datapath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_code  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for hid_keyboard_report_to_scancodes: stream reports in,
// predict the set 1 scancodes in the testbench and compare every output transaction.
// Depends only on the RTL top level; no package items are used.
`timescale 1ns / 1ps

module tb_top;

  localparam int KEY_SLOTS      = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 2 * (10 + 2 * KEY_SLOTS);
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_REPORTS = 125;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int MAX_SHOWN      = 10;

  localparam logic [7:0] RELEASE_BIT = 8'h80;
  localparam logic [7:0] SC_CTRL     = 8'h1D;
  localparam logic [7:0] SC_LSHIFT   = 8'h2A;
  localparam logic [7:0] SC_RSHIFT   = 8'h36;
  localparam logic [7:0] SC_ALT      = 8'h38;
  localparam logic [7:0] SC_NONE     = 8'h00;

  localparam logic [7:0] MODIFIER_CODE [8] = '{
    SC_CTRL, SC_LSHIFT, SC_ALT, SC_NONE,
    SC_CTRL, SC_RSHIFT, SC_ALT, SC_NONE
  };

  localparam logic [7:0] ALNUM_FIRST = 8'h04;
  localparam logic [7:0] ALNUM_CODES [46] = '{
    8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23,
    8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
    8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
    8'h15, 8'h2C, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h0A, 8'h0B, 8'h1C, 8'h01, 8'h0E, 8'h0F,
    8'h39, 8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B
  };
  localparam logic [7:0] PUNCT_FIRST = 8'h33;
  localparam logic [7:0] PUNCT_CODES [17] = '{
    8'h27, 8'h28, 8'h29, 8'h33, 8'h34, 8'h35, 8'h3A, 8'h3B,
    8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44
  };
  localparam logic [7:0] ARROW_FIRST = 8'h4F;
  localparam logic [7:0] ARROW_CODES [4] = '{8'h4D, 8'h4B, 8'h50, 8'h48};

  typedef logic [KEY_SLOTS-1:0][7:0] key_set_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } scancode_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [8+8*KEY_SLOTS-1:0] s_tdata;   // modifier_bits, key_slot0 .. key_slot5
  logic                     s_tuser;   // transfer_ok
  logic                     m_tvalid;
  logic                     m_tready;
  logic [7:0]               m_tdata;   // scancode
  logic                     m_tlast;   // last_of_run

  logic [7:0] set1_code [256];
  logic [7:0] held_mods;
  key_set_t   held_keys;
  scancode_t  pending_scancodes [$];

  bit src_idle        = 1'b1;
  bit sink_idle       = 1'b1;
  bit holdoff_request = 1'b0;
  int error_count     = 0;
  int reports_sent    = 0;
  int reports_dropped = 0;
  int scancodes_seen  = 0;
  int cycle_count     = 0;

  hid_keyboard_report_to_scancodes #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (set1_code[i]) set1_code[i] = 8'h00;
    foreach (ALNUM_CODES[i]) set1_code[ALNUM_FIRST + i] = ALNUM_CODES[i];
    foreach (PUNCT_CODES[i]) set1_code[PUNCT_FIRST + i] = PUNCT_CODES[i];
    foreach (ARROW_CODES[i]) set1_code[ARROW_FIRST + i] = ARROW_CODES[i];
  end

  function automatic void report_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic bit slot_has(input key_set_t set, input logic [7:0] code);
    for (int j = 0; j < KEY_SLOTS; j++)
      if (set[j] == code) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void queue_scancodes(input logic ok, input logic [7:0] mods,
                                          input key_set_t keys);
    scancode_t  run [$];
    logic [7:0] changed;
    logic [7:0] code;
    if (!ok) return;
    changed = mods ^ held_mods;
    for (int i = 0; i < 8; i++) begin
      if (changed[i] && MODIFIER_CODE[i] != SC_NONE) begin
        code = mods[i] ? MODIFIER_CODE[i] : (MODIFIER_CODE[i] | RELEASE_BIT);
        run.push_back('{code, 1'b0});
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      code = held_keys[i];
      if (code != 8'h00 && !slot_has(keys, code) && set1_code[code] != 8'h00)
        run.push_back('{set1_code[code] | RELEASE_BIT, 1'b0});
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      code = keys[i];
      if (code != 8'h00 && !slot_has(held_keys, code) && set1_code[code] != 8'h00)
        run.push_back('{set1_code[code], 1'b0});
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pending_scancodes.push_back(run[i]);
    held_mods = mods;
    held_keys = keys;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_usage();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(8'h04, 8'h52));
    if (r < 9) return 8'($urandom_range(0, 255));
    return 8'h00;
  endfunction

  function automatic key_set_t keys6(input logic [7:0] k0, k1, k2, k3, k4, k5);
    return {k5, k4, k3, k2, k1, k0};
  endfunction

  task automatic send_report(input logic ok, input logic [7:0] mods, input key_set_t keys);
    int gap;
    gap = src_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {keys, mods};
    s_tuser  <= ok;
    do @(posedge clk); while (!s_tready);
    reports_sent++;
    if (!ok) reports_dropped++;
    queue_scancodes(ok, mods, keys);
  endtask

  task automatic random_report();
    int         pick;
    logic       ok;
    logic [7:0] mods;
    logic [7:0] code;
    key_set_t   keys;
    pick = $urandom_range(0, 99);
    ok   = 1'b1;
    mods = held_mods;
    keys = held_keys;
    if (pick < 60) begin
      repeat ($urandom_range(1, 2))
        keys[$urandom_range(0, KEY_SLOTS - 1)] =
          ($urandom_range(0, 2) == 0) ? 8'h00 : pick_usage();
      if ($urandom_range(0, 2) == 0) mods[$urandom_range(0, 7)] ^= 1'b1;
    end else if (pick < 75) begin
      mods = 8'($urandom);
      keys = key_set_t'({$urandom, $urandom});
    end else if (pick < 87) begin
      ok   = 1'b0;
      mods = 8'($urandom);
      keys = key_set_t'({$urandom, $urandom});
    end else if (pick < 95) begin
      code = pick_usage();
      for (int i = 0; i < KEY_SLOTS; i++)
        if ($urandom_range(0, 1)) keys[i] = code;
    end else begin
      mods = 8'($urandom);
      keys = '0;
    end
    send_report(ok, mods, keys);
  endtask

  task automatic wait_for_drain(input int settle);
    s_tvalid <= 1'b0;
    while (pending_scancodes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic test_modifiers();
    send_report(1'b1, 8'hFF, '0);
    send_report(1'b1, 8'h00, '0);
    send_report(1'b1, 8'h88, '0);
    send_report(1'b1, 8'h00, '0);
    send_report(1'b1, 8'h55, '0);
    send_report(1'b1, 8'hAA, '0);
  endtask

  task automatic test_full_rollover();
    send_report(1'b1, 8'h00, keys6(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(1'b1, 8'h77, keys6(8'h52, 8'h51, 8'h50, 8'h4F, 8'h43, 8'h42));
    send_report(1'b1, 8'h77, keys6(8'h4F, 8'h42, 8'h52, 8'h43, 8'h51, 8'h50));
  endtask

  task automatic test_failed_transfer();
    send_report(1'b0, 8'h00, keys6(8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
    send_report(1'b1, 8'h77, keys6(8'h52, 8'h51, 8'h50, 8'h4F, 8'h43, 8'h42));
    send_report(1'b0, 8'hFF, {KEY_SLOTS{8'hFF}});
  endtask

  task automatic test_unmapped_codes();
    send_report(1'b1, 8'h77, keys6(8'h32, 8'h44, 8'hFF, 8'h01, 8'h03, 8'h53));
    send_report(1'b1, 8'h77, keys6(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1'b1, 8'hFF, {KEY_SLOTS{8'hFF}});
    send_report(1'b1, 8'h00, '0);
  endtask

  task automatic test_duplicate_slots();
    send_report(1'b1, 8'h00, keys6(8'h1E, 8'h04, 8'h1E, 8'h00, 8'h00, 8'h1E));
    send_report(1'b1, 8'h00, keys6(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1'b1, 8'h00, '0);
  endtask

  task automatic test_random_typing();
    repeat (RANDOM_REPORTS) random_report();
  endtask

  task automatic test_back_to_back();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (20) random_report();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  task automatic test_output_holdoff();
    src_idle        = 1'b0;
    holdoff_request = 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (i % 2 == 0)
        send_report(1'b1, 8'h77, keys6(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      else
        send_report(1'b1, 8'h00, keys6(8'h52, 8'h51, 8'h50, 8'h4F, 8'h43, 8'h42));
    end
    src_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) random_report();
    wait_for_drain(0);
    repeat (3) random_report();
  endtask

  initial begin : sink_ready
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        stall_left      = HOLDOFF_CYCLES;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    scancode_t want;
    if (!rst && m_tvalid && m_tready) begin
      scancodes_seen++;
      if (pending_scancodes.size() == 0) begin
        report_error($sformatf("unexpected scancode %02h last %0b", m_tdata, m_tlast));
      end else begin
        want = pending_scancodes.pop_front();
        if (m_tdata !== want.code || m_tlast !== want.last)
          report_error($sformatf("scancode %02h last %0b, expected %02h last %0b",
                                 m_tdata, m_tlast, want.code, want.last));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    held_mods = 8'h00;
    held_keys = '0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_modifiers();
    test_full_rollover();
    test_failed_transfer();
    test_unmapped_codes();
    test_duplicate_slots();
    test_random_typing();
    test_back_to_back();
    test_output_holdoff();
    test_drain_pause();

    wait_for_drain(DRAIN_CYCLES);
    if (pending_scancodes.size() != 0)
      report_error($sformatf("%0d scancodes never arrived", pending_scancodes.size()));

    $display("Summary: %0d reports sent (%0d discarded), %0d scancodes checked",
             reports_sent, reports_dropped, scancodes_seen);
    $display("Covered modifiers, rollover, failed transfers, unmapped and duplicate keys, stalls");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/hkbs_pkg.sv
design/hkbs_ctrl.sv
design/hkbs_datapath.sv
design/hid_keyboard_report_to_scancodes.sv
tb/sv/tb_top.sv
